/* hdl/address_port_registration_table_top_defines.svh */
// Assertion helpers for the table top RTL.
`ifndef ADDRESS_PORT_REGISTRATION_TABLE_TOP_DEFINES_SVH
`define ADDRESS_PORT_REGISTRATION_TABLE_TOP_DEFINES_SVH

// Checked on every rising clock edge once reset is released.
`define APRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define APRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/aprt_pkg.sv */
package aprt_pkg;

    // Operation codes.
    localparam logic [1:0] OP_REG = 2'd0;
    localparam logic [1:0] OP_QRY = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_CLR = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int KEY_BYTES = 16;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam logic [4:0] MAX_LEN = 5'd16;

    // One table slot; key holds address bytes 0 to 15, byte 0 in the top bits.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [4:0]       bytes;
        logic [15:0]      port;
    } t_entry;

    // Request and phase strobes broadcast to every cell.
    typedef struct packed {
        logic             cmp;
        logic             upd;
        logic [1:0]       op;
        logic             force_req;
        logic             ins;
        logic             any_hit;
        logic [15:0]      port;
        logic [KEY_W-1:0] addr;
    } t_ctrl;

    // Mask that selects the leading n bytes of a key (n from 0 to 16).
    function automatic logic [KEY_W-1:0] key_mask(input logic [4:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (5'(b) < n) begin
                m[KEY_W-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* hdl/aprt_cell.sv */
module aprt_cell
    import aprt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  t_entry      i_prev,
    input  t_entry      i_next,
    input  logic        i_hit_prior,
    input  logic [15:0] i_port_chain,
    output t_entry      o_entry,
    output logic        o_hit_prior,
    output logic [15:0] o_port_chain
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;
    logic   n_match;
    logic   w_first_hit;

    // This cell holds the newest match when no newer cell matched.
    assign w_first_hit  = r_match && !i_hit_prior;
    assign o_hit_prior  = i_hit_prior || r_match;
    assign o_port_chain = i_hit_prior ? i_port_chain : (r_match ? r_entry.port : 16'h0000);
    assign o_entry      = r_entry;

    // Compare in the first phase, shift or update in the second.
    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        if (i_ctrl.cmp) begin
            n_match = r_entry.valid &&
                      (((r_entry.key ^ i_ctrl.addr) & key_mask(r_entry.bytes)) == '0);
        end
        if (i_ctrl.upd) begin
            case (i_ctrl.op)
                OP_REG: begin
                    if (i_ctrl.ins) begin
                        n_entry = i_prev;
                    end else if (w_first_hit && i_ctrl.force_req) begin
                        n_entry.port = i_ctrl.port;
                    end
                end
                OP_DEL: begin
                    if (i_ctrl.any_hit && (i_hit_prior || r_match)) begin
                        n_entry = i_next;
                    end
                end
                OP_CLR: begin
                    n_entry.valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Key and port are read only behind a set valid bit, so only the flags are reset.
    always_ff @(posedge i_clk) begin
        r_entry.key   <= n_entry.key;
        r_entry.bytes <= n_entry.bytes;
        r_entry.port  <= n_entry.port;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
            r_match       <= n_match;
        end
    end

endmodule

/* hdl/address_port_registration_table_top.sv */
// An accepted request runs a compare phase, then an update phase, then a result strobe.
// Accepts overlap the update phase; busy is high for the cycle after each accept.
// The update phase carries the newest-match priority chain through all cells.
// Reset empties the table at once; results go out for one cycle and are never stalled.
`include "address_port_registration_table_top_defines.svh"

module address_port_registration_table_top
    import aprt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [4:0]  i_addr_bytes,
    input  logic [15:0] i_port_value,
    input  logic        i_force_req,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_port_found
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    logic [1:0]       r_phase;
    logic [1:0]       n_phase;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_addr;
    logic [4:0]       r_len;
    logic [15:0]      r_port;
    logic             r_force;
    logic             w_accept;
    logic             w_any_hit;
    logic             w_full;
    logic [1:0]       n_status;
    logic [15:0]      n_port_found;
    t_ctrl            w_ctrl;
    t_entry           w_new;
    t_entry           w_empty;

    t_entry             w_entry [TABLE_ENTRIES];
    logic               w_hit   [TABLE_ENTRIES+1];
    logic [15:0]        w_pchain[TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_valid_vec;

    assign busy     = (r_phase == PH_CMP);
    assign w_accept = start && !busy;

    // Sequencer: compare phase, then update phase overlapping the next accept.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_CMP:  n_phase = PH_UPD;
            default: n_phase = w_accept ? PH_CMP : PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            o_valid <= (r_phase == PH_UPD);
        end
    end

    // Request register; lengths above sixteen saturate.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_addr  <= {i_addr_high, i_addr_low};
            r_len   <= (i_addr_bytes > MAX_LEN) ? MAX_LEN : i_addr_bytes;
            r_port  <= i_port_value;
            r_force <= i_force_req;
        end
    end

    // Entry that enters at the newest slot, and the one that fills the oldest on delete.
    always_comb begin
        w_new.valid = 1'b1;
        w_new.key   = r_addr & key_mask(r_len);
        w_new.bytes = r_len;
        w_new.port  = r_port;
        w_empty     = '0;
    end

    assign w_any_hit = w_hit[TABLE_ENTRIES];
    assign w_full    = w_entry[TABLE_ENTRIES-1].valid;

    always_comb begin
        w_ctrl.cmp       = (r_phase == PH_CMP);
        w_ctrl.upd       = (r_phase == PH_UPD);
        w_ctrl.op        = r_op;
        w_ctrl.force_req = r_force;
        w_ctrl.ins       = (r_op == OP_REG) && !w_any_hit && !w_full;
        w_ctrl.any_hit   = w_any_hit;
        w_ctrl.port      = r_port;
        w_ctrl.addr      = r_addr;
    end

    assign w_hit[0]    = 1'b0;
    assign w_pchain[0] = 16'h0000;

    // Row of cells, slot 0 newest.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;

        if (g == 0) begin : g_head
            assign w_prev = w_new;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign w_next = w_empty;
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        aprt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .i_hit_prior  (w_hit[g]),
            .i_port_chain (w_pchain[g]),
            .o_entry      (w_entry[g]),
            .o_hit_prior  (w_hit[g+1]),
            .o_port_chain (w_pchain[g+1])
        );

        assign w_valid_vec[g] = w_entry[g].valid;
    end

    // Result of the request in its update phase.
    always_comb begin
        n_status     = ST_OK;
        n_port_found = 16'h0000;
        case (r_op)
            OP_REG: begin
                if (w_any_hit) begin
                    n_status = ST_MISS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            OP_QRY: begin
                if (w_any_hit) begin
                    n_port_found = w_pchain[TABLE_ENTRIES];
                end else begin
                    n_status = ST_MISS;
                end
            end
            OP_DEL: begin
                if (!w_any_hit) begin
                    n_status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_UPD) begin
            o_status     <= n_status;
            o_port_found <= n_port_found;
        end
    end

    // The compare phase is always followed by the update phase.
    `APRT_ASSERT(a_cmp_then_upd, (r_phase == PH_CMP) |=> (r_phase == PH_UPD), "update phase missed")
    // A result strobe only follows an update phase.
    `APRT_ASSERT(a_strobe_src, o_valid |-> ($past(r_phase) == PH_UPD), "stray result strobe")
    // Valid slots stay packed toward the newest end.
    `APRT_ASSERT(a_compact, (w_valid_vec & (w_valid_vec + TABLE_ENTRIES'(1))) == '0, "table has a gap")
    // A nonzero port only comes with a successful status.
    `APRT_ASSERT(a_port_ok, (o_valid && (o_port_found != 16'h0000)) |-> (o_status == ST_OK),
        "port on failed request")
    // No request is taken while the compare phase runs.
    `APRT_ASSERT_ALWAYS(a_no_accept_busy, (busy && start) |=> (r_phase == PH_UPD || !i_rst_n ||
        $past(!i_rst_n)), "request taken while busy")

endmodule

/* tb/port_table_checker.sv */
module port_table_checker
    import aprt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [4:0]  i_addr_bytes,
    input  logic [15:0] i_port_value,
    input  logic        i_force_req,
    input  logic        i_valid,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_port_found,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port;
    } t_reply;

    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    // Shadow copy of the table, kept compact with slot 0 as the newest entry.
    logic [KEY_W-1:0] slot_key  [TABLE_ENTRIES];
    logic [4:0]       slot_len  [TABLE_ENTRIES];
    logic [15:0]      slot_port [TABLE_ENTRIES];
    int               used = 0;

    t_reply expected_replies[$];
    int     mismatches = 0;

    // Leading n bytes of a key set to ones, the rest zero.
    function automatic logic [KEY_W-1:0] prefix_mask(input logic [4:0] n);
        return ~(ALL_ONES >> (8 * n));
    endfunction

    // Slot of the newest entry whose stored prefix matches the address, or -1.
    function automatic int newest_match(input logic [KEY_W-1:0] addr);
        for (int i = 0; i < used; i++) begin
            if (((slot_key[i] ^ addr) & prefix_mask(slot_len[i])) == '0) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the reply it must give.
    function automatic t_reply table_request(input logic [1:0] op,
                                             input logic [KEY_W-1:0] addr,
                                             input logic [4:0] len_in,
                                             input logic [15:0] port,
                                             input logic overwrite);
        t_reply     r;
        int         hit;
        logic [4:0] len;
        r.status = ST_OK;
        r.port   = '0;
        len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
        hit = newest_match(addr);
        case (op)
            OP_REG: begin
                if (hit >= 0) begin
                    // An existing match keeps its place and length.
                    if (overwrite) begin
                        slot_port[hit] = port;
                    end
                    r.status = ST_MISS;
                end else if (used >= TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = used; i > 0; i--) begin
                        slot_key[i]  = slot_key[i-1];
                        slot_len[i]  = slot_len[i-1];
                        slot_port[i] = slot_port[i-1];
                    end
                    slot_key[0]  = addr & prefix_mask(len);
                    slot_len[0]  = len;
                    slot_port[0] = port;
                    used++;
                end
            end
            OP_QRY: begin
                if (hit >= 0) begin
                    r.port = slot_port[hit];
                end else begin
                    r.status = ST_MISS;
                end
            end
            OP_DEL: begin
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    // Close the gap so the table stays in age order.
                    for (int i = hit; i < used - 1; i++) begin
                        slot_key[i]  = slot_key[i+1];
                        slot_len[i]  = slot_len[i+1];
                        slot_port[i] = slot_port[i+1];
                    end
                    used--;
                end
            end
            default: begin
                used = 0;
            end
        endcase
        return r;
    endfunction

    // Predict on every accepted request, compare every result strobe.
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            used = 0;
            expected_replies.delete();
        end else begin
            if (i_start && !i_busy) begin
                expected_replies.push_back(table_request(i_operation,
                    {i_addr_high, i_addr_low}, i_addr_bytes, i_port_value, i_force_req));
            end
            if (i_valid) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: status %0d port %h", $time,
                             i_status, i_port_found);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                                 want.status, i_status);
                    end
                    if (i_port_found !== want.port) begin
                        mismatches++;
                        $display("%0t: port mismatch: expected %h, actual %h", $time,
                                 want.port, i_port_found);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_replies.size();
    end

endmodule

/* tb/tb_top.sv */
module tb_top
    import aprt_pkg::*;
();

    localparam int TABLE_ENTRIES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int POOL_SIZE     = 32;
    localparam int PHASE_ITEMS   = 550;
    localparam logic [127:0] ALL_ONES = '1;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  i_operation  = OP_QRY;
    logic [63:0] i_addr_high  = '0;
    logic [63:0] i_addr_low   = '0;
    logic [4:0]  i_addr_bytes = '0;
    logic [15:0] i_port_value = '0;
    logic        i_force_req  = 1'b0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_port_found;

    int fail_count;
    int pending;
    int cycle_count = 0;

    logic [127:0] addr_pool [POOL_SIZE];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    address_port_registration_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_addr_high  (i_addr_high),
        .i_addr_low   (i_addr_low),
        .i_addr_bytes (i_addr_bytes),
        .i_port_value (i_port_value),
        .i_force_req  (i_force_req),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_port_found (o_port_found)
    );

    port_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_operation  (i_operation),
        .i_addr_high  (i_addr_high),
        .i_addr_low   (i_addr_low),
        .i_addr_bytes (i_addr_bytes),
        .i_port_value (i_port_value),
        .i_force_req  (i_force_req),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_port_found (o_port_found),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [127:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Presents one request, holds it until accepted, then maybe idles a while.
    task automatic send_request(input logic [1:0] op, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [4:0] len,
                                input logic [15:0] port, input logic overwrite,
                                input int idle_pct);
        i_operation  <= op;
        i_addr_high  <= hi;
        i_addr_low   <= lo;
        i_addr_bytes <= len;
        i_port_value <= port;
        i_force_req  <= overwrite;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Mostly addresses from a shared pool, often with a random tail, so that
    // registrations collide, queries hit, and the table fills up.
    task automatic random_request(input int idle_pct);
        logic [1:0]   op;
        logic [127:0] addr;
        logic [127:0] tail;
        logic [4:0]   len;
        int           pick;
        int           keep;
        pick = $urandom_range(0, 199);
        if (pick < 88) begin
            op = OP_REG;
        end else if (pick < 148) begin
            op = OP_QRY;
        end else if (pick < 197) begin
            op = OP_DEL;
        end else begin
            op = OP_CLR;
        end
        if ($urandom_range(0, 99) < 70) begin
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 99) < 40) begin
                keep = $urandom_range(4, 16);
                tail = ALL_ONES >> (8 * keep);
                addr = (addr & ~tail) | (random_key() & tail);
            end
        end else begin
            addr = random_key();
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = 5'd4;
        end else if (pick < 85) begin
            len = 5'd16;
        end else if (pick < 98) begin
            len = 5'($urandom_range(1, 31));
        end else begin
            len = 5'd0;
        end
        send_request(op, addr[127:64], addr[63:0], len, 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), idle_pct);
    endtask

    initial begin : stimulus
        logic [63:0] addr_a;
        logic [31:0] prefixes [8];
        int          idle_pct [3];
        int          drain;
        idle_pct[0] = 27;
        idle_pct[1] = 72;
        idle_pct[2] = 0;
        addr_a = 64'hC0A8_0101_0000_0000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, existing entries with and without force,
        // saturated length, zero-length wildcard, full table, clear.
        send_request(OP_QRY, addr_a, '0, 5'd4, '0, 1'b0, 0);
        send_request(OP_REG, addr_a, '0, 5'd4, 16'hFFFF, 1'b0, 0);
        send_request(OP_REG, addr_a | 64'h0000_0000_1234_5678, ALL_ONES[63:0], 5'd16,
                     16'h1111, 1'b0, 0);
        send_request(OP_REG, addr_a | 64'h0000_0000_00FF_0000, '0, 5'd0, 16'h0000, 1'b1, 0);
        send_request(OP_QRY, addr_a, '0, 5'd0, '0, 1'b0, 0);
        send_request(OP_REG, ALL_ONES[63:0], ALL_ONES[63:0], 5'd31, 16'h1234, 1'b0, 0);
        send_request(OP_QRY, ALL_ONES[63:0], 64'hFFFF_FFFF_FFFF_FFFE, 5'd16, '0, 1'b0, 0);
        send_request(OP_REG, {8'h11, 56'($urandom)}, {$urandom, $urandom}, 5'd0, 16'h5A5A,
                     1'b0, 0);
        send_request(OP_QRY, {$urandom, $urandom}, {$urandom, $urandom}, 5'd4, '0, 1'b0, 0);
        send_request(OP_DEL, {8'h22, 56'($urandom)}, {$urandom, $urandom}, 5'd4, '0, 1'b0, 0);
        for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
            send_request(OP_REG, {8'(i + 1), 56'($urandom)}, {$urandom, $urandom}, 5'd4,
                         16'($urandom_range(0, 65535)), 1'b0, 0);
        end
        send_request(OP_REG, {8'h30, 56'($urandom)}, {$urandom, $urandom}, 5'd16, 16'hBEEF,
                     1'b0, 0);
        send_request(OP_CLR, '0, '0, 5'd0, '0, 1'b0, 0);

        // Address pool: few distinct leading words so prefixes overlap.
        foreach (prefixes[i]) prefixes[i] = $urandom;
        foreach (addr_pool[i]) begin
            addr_pool[i] = {prefixes[$urandom_range(0, 7)], 96'(random_key())};
        end

        for (int p = 0; p < 3; p++) begin
            repeat (PHASE_ITEMS) random_request(idle_pct[p]);
        end
        start <= 1'b0;

        // Let the last results come back.
        @(posedge i_clk);
        drain = 0;
        while (pending != 0 && drain < 50) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (6) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
